// ----- hdl/mrtu_pkg.sv -----
// ----------------------------------------------------------------------------
// mrtu_pkg: shared types and constants for the Modbus RTU master frame engine
// Opcodes, kinds, status codes, the front-to-back command and the CRC step.
// ----------------------------------------------------------------------------
`default_nettype none
package mrtu_pkg;

  localparam int MaxReplyLen = 256;
  localparam int FcUserBase  = 65;
  localparam int QDepth      = 2;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_RXBYTE  = 2'd2,
    OP_RXEND   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_FRAME  = 2'd0,
    K_DATA   = 2'd1,
    K_STATUS = 2'd2
  } kind_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADARG   = 3'd1;
  localparam logic [2:0] ST_TIMEOUT  = 3'd2;
  localparam logic [2:0] ST_CRC      = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;

  localparam logic [2:0] F_RD_COILS = 3'd0;
  localparam logic [2:0] F_RD_REGS  = 3'd1;
  localparam logic [2:0] F_WR_COIL  = 3'd2;
  localparam logic [2:0] F_WR_REG   = 3'd3;
  localparam logic [2:0] F_WR_REGS  = 3'd4;
  localparam logic [2:0] F_RD_BYTES = 3'd5;
  localparam logic [2:0] F_WR_BYTES = 3'd6;

  // command from the front classifier to the back sequencer
  typedef enum logic [2:0] {
    C_STATUS = 3'd0,  // emit status only
    C_START  = 3'd1,  // build and send request header
    C_PAY    = 3'd2,
    C_RXBYTE = 3'd3,
    C_RXEND  = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [2:0]  func;
    logic [2:0]  status;
    logic [7:0]  slave;
    logic [15:0] mem_addr;
    logic [10:0] count;
    logic [15:0] value;
    logic [8:0]  exp_len;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_RECV = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_EMIT = 2'd1
  } bstate_t;

  // one byte of CRC-16/MODBUS, eight bit steps on a 16-bit value
  function automatic logic [15:0] crc_upd(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/mrtu_front.sv -----
// ----------------------------------------------------------------------------
// mrtu_front: input classifier
// Checks request arguments, computes the expected reply length, issues a command.
// ----------------------------------------------------------------------------
`default_nettype none
module mrtu_front (
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [1:0]         in_op,
  input  wire  [7:0]         in_slave,
  input  wire  [2:0]         in_func,
  input  wire  [15:0]        in_mem_addr,
  input  wire  [10:0]        in_count,
  input  wire  [15:0]        in_value,
  output mrtu_pkg::cmd_t     q_data,
  output logic               q_valid,
  input  wire                q_full
);
  import mrtu_pkg::*;

  logic        bad;
  logic        empty_wr;
  logic [11:0] exp;

  assign in_stall = q_full;
  assign q_valid  = in_valid && !q_full;

  // classify a start request
  always_comb begin
    bad      = 1'b0;
    empty_wr = 1'b0;
    exp      = 12'd8;
    unique case (in_func)
      F_RD_COILS: begin
        bad = (in_count == 11'd0) || (in_count >= 11'h7D1);
        exp = 12'd5 + ({1'b0, in_count} + 12'd7 >> 3);
      end
      F_RD_REGS: begin
        bad = (in_count == 11'd0) || (in_count >= 11'h07E);
        exp = 12'd5 + {in_count, 1'b0};
      end
      F_WR_COIL, F_WR_REG: ;
      F_WR_REGS: begin
        empty_wr = (in_count == 11'd0);
        bad      = (in_count >= 11'h07C);
      end
      F_RD_BYTES: begin
        bad = (in_count == 11'd0) || (in_count >= 11'd250);
        exp = 12'd7 + {1'b0, in_count};
      end
      F_WR_BYTES: begin
        empty_wr = (in_count == 11'd0);
        bad      = (in_count >= 11'd250);
        exp      = 12'd7;
      end
      default: bad = 1'b1;
    endcase
    if (exp > 12'(MaxReplyLen)) bad = 1'b1;
  end

  // build the command
  always_comb begin
    q_data          = '0;
    q_data.func     = in_func;
    q_data.slave    = in_slave;
    q_data.mem_addr = in_mem_addr;
    q_data.count    = in_count;
    q_data.value    = in_value;
    q_data.exp_len  = exp[8:0];
    unique case (op_t'(in_op))
      OP_START: begin
        if (empty_wr) begin
          q_data.op = C_STATUS; q_data.status = ST_OK;
        end else if (bad) begin
          q_data.op = C_STATUS; q_data.status = ST_BADARG;
        end else begin
          q_data.op = C_START;
        end
      end
      OP_PAYLOAD: q_data.op = C_PAY;
      OP_RXBYTE:  q_data.op = C_RXBYTE;
      default:    q_data.op = C_RXEND;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/mrtu_queue.sv -----
// ----------------------------------------------------------------------------
// mrtu_queue: small command FIFO
// Decouples the classifier from the back sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module mrtu_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               wr_en,
  input  mrtu_pkg::cmd_t    wr_data,
  output logic              full,
  output logic              rd_valid,
  output mrtu_pkg::cmd_t    rd_data,
  input  wire               rd_en
);
  import mrtu_pkg::*;

  localparam int AW = $clog2(QDepth);

  cmd_t         mem_r [QDepth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full     = (cnt_r == (AW+1)'(QDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];

  // store entries
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mrtu_back.sv -----
// ----------------------------------------------------------------------------
// mrtu_back: transaction sequencer
// Emits frame bytes one a cycle unless stalled, tracks payload and reply, checks echo and CRC.
// ----------------------------------------------------------------------------
`default_nettype none
module mrtu_back (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               q_valid,
  input  mrtu_pkg::cmd_t    q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_frame_byte,
  output logic [15:0]       out_reply_data,
  output logic [2:0]        out_status,
  output logic              out_last
);
  import mrtu_pkg::*;

  // transaction state
  phase_t      phase_r, phase_nxt;
  logic [2:0]  rkind_r, rkind_nxt;
  logic [7:0]  hdr_r [6];
  logic [7:0]  pleft_r, pleft_nxt;
  logic [15:0] txcrc_r, txcrc_nxt;
  logic [15:0] rxcrc_r, rxcrc_nxt;
  logic [8:0]  explen_r, explen_nxt;
  logic [8:0]  rxlen_r, rxlen_nxt;
  logic        mism_r, mism_nxt;
  logic [7:0]  hihold_r, hihold_nxt;
  logic [7:0]  crclo_r, crclo_nxt;

  // byte sequence for the current item
  bstate_t     bst_r, bst_nxt;
  logic [7:0]  seq_r [7];
  logic [2:0]  seqlen_r;
  logic [2:0]  seqi_r, seqi_nxt;
  logic        seqcrc_r;   // CRC follows the listed bytes
  logic [1:0]  crci_r, crci_nxt;
  logic        load;

  // output register
  logic        ov_r;
  logic [1:0]  ok_r;
  logic [7:0]  ofb_r;
  logic [15:0] ord_r;
  logic [2:0]  ost_r;
  logic        ol_r;
  logic        ofree;

  logic        emit;
  logic [1:0]  ek;
  logic [7:0]  efb;
  logic [15:0] erd;
  logic [2:0]  est;
  logic        el;

  logic [7:0]  sb [7];
  logic [2:0]  sl;
  logic        sc;
  logic        setrecv;

  logic [7:0]  rb;
  logic [8:0]  idx;
  logic [2:0]  cmplen;
  logic [8:0]  dstart;
  logic [15:0] got;
  logic [7:0]  cur;
  logic        crcdone;

  assign ofree          = !ov_r || !out_stall;
  assign out_valid      = ov_r;
  assign out_kind       = ok_r;
  assign out_frame_byte = ofb_r;
  assign out_reply_data = ord_r;
  assign out_status     = ost_r;
  assign out_last       = ol_r;
  assign rb             = q_data.value[7:0];
  assign idx            = rxlen_r;

  // next state of the byte sequencer
  always_comb begin
    bst_nxt = bst_r;
    unique case (bst_r)
      B_IDLE: if (load && (sl != 3'd0 || sc)) bst_nxt = B_EMIT;
      B_EMIT: if (ofree && crcdone) bst_nxt = B_IDLE;
      default: bst_nxt = B_IDLE;
    endcase
  end

  // flag the byte that closes the sequence: CRC high byte, or else the last listed byte
  assign crcdone = seqcrc_r ? ((seqi_r == seqlen_r) && (crci_r == 2'd1))
                            : (seqi_r == seqlen_r - 3'd1);
  assign cur     = seq_r[seqi_r];

  // command decode and emission
  always_comb begin
    phase_nxt = phase_r; rkind_nxt = rkind_r; pleft_nxt = pleft_r;
    txcrc_nxt = txcrc_r; rxcrc_nxt = rxcrc_r; explen_nxt = explen_r;
    rxlen_nxt = rxlen_r; mism_nxt = mism_r; hihold_nxt = hihold_r;
    crclo_nxt = crclo_r; seqi_nxt = seqi_r; crci_nxt = crci_r;
    emit = 1'b0; ek = K_FRAME; efb = '0; erd = '0; est = '0; el = 1'b0;
    load = 1'b0; q_pop = 1'b0; setrecv = 1'b0;
    for (int i = 0; i < 7; i++) sb[i] = '0;
    sl = 3'd0; sc = 1'b0;
    cmplen = (rkind_r <= F_RD_REGS) ? 3'd2 : ((rkind_r >= F_RD_BYTES) ? 3'd5 : 3'd6);
    dstart = (rkind_r <= F_RD_REGS) ? 9'd3 : ((rkind_r == F_RD_BYTES) ? 9'd5 : 9'h1FF);
    got = {rb, crclo_r};

    if (bst_r == B_EMIT) begin
      // one frame byte a cycle when the output is not stalled
      if (ofree) begin
        emit = 1'b1; el = crcdone;
        if (seqi_r != seqlen_r) begin
          efb = cur; txcrc_nxt = crc_upd(txcrc_r, cur); seqi_nxt = seqi_r + 3'd1;
        end else if (crci_r == 2'd0) begin
          efb = txcrc_r[7:0]; crci_nxt = 2'd1;
        end else begin
          efb = txcrc_r[15:8];
        end
      end
    end else if (q_valid && ofree) begin
      q_pop = 1'b1;
      unique case (q_data.op)
        C_STATUS: begin
          phase_nxt = PH_IDLE;
          emit = 1'b1; ek = K_STATUS; est = q_data.status; el = 1'b1;
        end
        C_START: begin
          rkind_nxt = q_data.func; explen_nxt = q_data.exp_len; txcrc_nxt = 16'hFFFF;
          sb[0] = q_data.slave; sb[2] = q_data.mem_addr[15:8]; sb[3] = q_data.mem_addr[7:0];
          sl = 3'd6;
          unique case (q_data.func)
            F_RD_COILS, F_RD_REGS: begin
              sb[1] = (q_data.func == F_RD_COILS) ? 8'd1 : 8'd3;
              sb[4] = {5'd0, q_data.count[10:8]}; sb[5] = q_data.count[7:0];
            end
            F_WR_COIL: begin
              sb[1] = 8'd5; sb[4] = (q_data.value != 16'd0) ? 8'hFF : 8'h00;
            end
            F_WR_REG: begin
              sb[1] = 8'd6; sb[4] = q_data.value[15:8]; sb[5] = q_data.value[7:0];
            end
            F_WR_REGS: begin
              sb[1] = 8'd16; sb[5] = q_data.count[7:0];
              sb[6] = {q_data.count[6:0], 1'b0}; sl = 3'd7;
            end
            default: begin
              sb[1] = (q_data.func == F_RD_BYTES) ? 8'(FcUserBase) : 8'(FcUserBase + 1);
              sb[4] = q_data.count[7:0]; sl = 3'd5;
            end
          endcase
          if (q_data.func == F_WR_REGS || q_data.func == F_WR_BYTES) begin
            pleft_nxt = q_data.count[7:0]; phase_nxt = PH_SEND;
          end else begin
            sc = 1'b1; setrecv = 1'b1;
          end
          load = 1'b1;
        end
        C_PAY: begin
          if (phase_r == PH_SEND) begin
            if (rkind_r == F_WR_REGS) begin
              sb[0] = q_data.value[15:8]; sb[1] = q_data.value[7:0]; sl = 3'd2;
            end else begin
              sb[0] = q_data.value[7:0]; sl = 3'd1;
            end
            pleft_nxt = pleft_r - 8'd1;
            if (pleft_r == 8'd1) begin
              sc = 1'b1; setrecv = 1'b1;
            end
            load = 1'b1;
          end
        end
        C_RXBYTE: begin
          if (phase_r == PH_RECV && explen_r >= 9'd3 && idx < explen_r) begin
            rxlen_nxt = idx + 9'd1;
            if (idx < explen_r - 9'd2) begin
              rxcrc_nxt = crc_upd(rxcrc_r, rb);
              if (idx < {6'd0, cmplen} && rb != hdr_r[idx[2:0]]) mism_nxt = 1'b1;
              if (idx >= dstart) begin
                if (rkind_r == F_RD_REGS && !(idx[0] ^ dstart[0])) begin
                  hihold_nxt = rb;
                end else begin
                  emit = 1'b1; ek = K_DATA; el = 1'b1;
                  erd = (rkind_r == F_RD_REGS) ? {hihold_r, rb} : {8'd0, rb};
                end
              end
            end else if (idx == explen_r - 9'd2) begin
              crclo_nxt = rb;
            end else begin
              emit = 1'b1; ek = K_STATUS; el = 1'b1; phase_nxt = PH_IDLE;
              est = (got != rxcrc_r) ? ST_CRC : (mism_r ? ST_MISMATCH : ST_OK);
            end
          end
        end
        default: begin
          if (phase_r == PH_RECV) begin
            phase_nxt = PH_IDLE;
            emit = 1'b1; ek = K_STATUS; el = 1'b1;
            est = (rxlen_r == 9'd0) ? ST_TIMEOUT : ST_CRC;
          end
        end
      endcase
      if (setrecv) begin
        phase_nxt = PH_RECV; rxcrc_nxt = 16'hFFFF; rxlen_nxt = '0;
        mism_nxt = 1'b0; hihold_nxt = '0; crclo_nxt = '0;
      end
      if (load) begin
        seqi_nxt = 3'd0; crci_nxt = 2'd0;
      end
    end
  end

  // hold sequence and header bytes
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 7; i++) seq_r[i] <= sb[i];
      seqlen_r <= sl;
      seqcrc_r <= sc;
    end
    if (load && q_data.op == C_START) begin
      for (int i = 0; i < 6; i++) hdr_r[i] <= sb[i];
    end
    if (ofree) begin
      ok_r <= ek; ofb_r <= efb; ord_r <= erd; ost_r <= est; ol_r <= el;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; rkind_r <= '0; pleft_r <= '0; txcrc_r <= 16'hFFFF;
      rxcrc_r <= 16'hFFFF; explen_r <= '0; rxlen_r <= '0; mism_r <= 1'b0;
      hihold_r <= '0; crclo_r <= '0; bst_r <= B_IDLE; seqi_r <= '0; crci_r <= '0;
      ov_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; rkind_r <= rkind_nxt; pleft_r <= pleft_nxt;
      txcrc_r <= txcrc_nxt; rxcrc_r <= rxcrc_nxt; explen_r <= explen_nxt;
      rxlen_r <= rxlen_nxt; mism_r <= mism_nxt; hihold_r <= hihold_nxt;
      crclo_r <= crclo_nxt; bst_r <= bst_nxt; seqi_r <= seqi_nxt; crci_r <= crci_nxt;
      if (ofree) ov_r <= emit;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/modbus_rtu_master_frame_engine.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_master_frame_engine: Modbus RTU master request/reply engine
// Classifier front, two-entry command queue, byte sequencer back.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | op, slave, func, mem_addr, count, value
// out     | output    | out_valid/out_stall| kind, frame_byte, reply_data, status, last
//
// An item that sends frame bytes first loads its byte list in the back, then emits
// the bytes in order (a request of 8 bytes is header plus CRC); the back pops no
// new item until the last byte is out. Every item passes through the queue registers.
// Reset (synchronous, rst_n low) empties the queue and idles the engine.
// Output stall holds the result register; the queue then fills and stalls the input.
`default_nettype none
module modbus_rtu_master_frame_engine (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_op,
  input  wire  [7:0]  in_slave,
  input  wire  [2:0]  in_func,
  input  wire  [15:0] in_mem_addr,
  input  wire  [10:0] in_count,
  input  wire  [15:0] in_value,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_frame_byte,
  output logic [15:0] out_reply_data,
  output logic [2:0]  out_status,
  output logic        out_last
);
  import mrtu_pkg::*;

  cmd_t wcmd, rcmd;
  logic wen, full, rvalid, pop;

  mrtu_front u_front (
    .in_valid, .in_stall, .in_op, .in_slave, .in_func,
    .in_mem_addr, .in_count, .in_value,
    .q_data(wcmd), .q_valid(wen), .q_full(full)
  );

  mrtu_queue u_queue (
    .clk, .rst_n, .wr_en(wen), .wr_data(wcmd), .full,
    .rd_valid(rvalid), .rd_data(rcmd), .rd_en(pop)
  );

  mrtu_back u_back (
    .clk, .rst_n, .q_valid(rvalid), .q_data(rcmd), .q_pop(pop),
    .out_valid, .out_stall, .out_kind, .out_frame_byte, .out_reply_data,
    .out_status, .out_last
  );

  // result kind is one of the three defined codes
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind != 2'd3))
    else $error("bad result kind");

  // a status result always closes its item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == K_STATUS) |-> out_last)
    else $error("status without last");

  // queue never pops when empty
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rvalid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- dv/modbus_rtu_master_frame_engine_tb.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_master_frame_engine_tb: self-checking bench for the RTU master engine
// Sends requests, payload items and reply bytes, predicts every frame byte,
// data element and status, and compares each result in order. Both sides idle.
// ----------------------------------------------------------------------------
module modbus_rtu_master_frame_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrtu_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_byte;
    logic [15:0] reply_data;
    logic [2:0]  status;
    logic        last;
  } result_t;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [1:0]  in_op;
  logic [7:0]  in_slave;
  logic [2:0]  in_func;
  logic [15:0] in_mem_addr;
  logic [10:0] in_count;
  logic [15:0] in_value;
  logic        out_valid, out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_frame_byte;
  logic [15:0] out_reply_data;
  logic [2:0]  out_status;
  logic        out_last;

  modbus_rtu_master_frame_engine DUT (.*);

  // predictor state
  phase_t      m_phase;
  logic [2:0]  m_kind;
  logic [7:0]  m_hdr [6];
  logic [7:0]  m_left;
  logic [15:0] m_txcrc, m_rxcrc;
  logic [8:0]  m_explen, m_rxlen;
  logic        m_mis;
  logic [7:0]  m_hi, m_crclo;

  result_t expected_q[$];
  int      errors = 0;
  int      n_items = 0;
  int      n_results = 0;
  int      idle_cycles = 0;
  int      stall_hold = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic push_res(logic [1:0] k, logic [7:0] fb, logic [15:0] rd, logic [2:0] st);
    result_t r;
    r = '{kind: k, frame_byte: fb, reply_data: rd, status: st, last: 1'b0};
    expected_q = {expected_q, r};
  endtask

  task automatic push_frame(logic [7:0] b);
    m_txcrc = crc_step(m_txcrc, b);
    push_res(K_FRAME, b, 16'h0, ST_OK);
  endtask

  task automatic push_crc();
    push_res(K_FRAME, m_txcrc[7:0], 16'h0, ST_OK);
    push_res(K_FRAME, m_txcrc[15:8], 16'h0, ST_OK);
    m_phase = PH_RECV;
    m_rxcrc = 16'hFFFF;
    m_rxlen = 0;
    m_mis = 0;
    m_hi = 0;
    m_crclo = 0;
  endtask

  // compute expected results for one accepted item
  task automatic predict_engine(logic [1:0] op, logic [7:0] s, logic [2:0] f,
                                logic [15:0] a, logic [10:0] c, logic [15:0] v);
    logic [7:0] h[7];
    int hl, exp_len, idx, cmp_len, dstart, n0;
    logic bad;
    logic [15:0] got;
    logic [2:0] st;
    n0 = expected_q.size();
    case (op)
      OP_START: begin
        m_phase = PH_IDLE;
        hl = 6; exp_len = 8; bad = 0;
        h[0] = s; h[2] = a[15:8]; h[3] = a[7:0];
        h[1] = 0; h[4] = 0; h[5] = 0; h[6] = 0;
        case (f)
          F_RD_COILS: begin
            bad = (c == 0) || (c > 2000);
            h[1] = 8'd1; h[4] = {5'b0, c[10:8]}; h[5] = c[7:0];
            exp_len = 5 + ((c + 7) >> 3);
          end
          F_RD_REGS: begin
            bad = (c == 0) || (c > 125);
            h[1] = 8'd3; h[4] = {5'b0, c[10:8]}; h[5] = c[7:0];
            exp_len = 5 + 2 * c;
          end
          F_WR_COIL: begin
            h[1] = 8'd5; h[4] = (v != 0) ? 8'hFF : 8'h00;
          end
          F_WR_REG: begin
            h[1] = 8'd6; h[4] = v[15:8]; h[5] = v[7:0];
          end
          F_WR_REGS: begin
            bad = c > 123;
            h[1] = 8'd16; h[5] = c[7:0]; h[6] = 8'(2 * c); hl = 7;
          end
          F_RD_BYTES: begin
            bad = (c == 0) || (c > 249);
            h[1] = 8'(FcUserBase); h[4] = c[7:0]; hl = 5;
            exp_len = 7 + c;
          end
          F_WR_BYTES: begin
            bad = c > 249;
            h[1] = 8'(FcUserBase + 1); h[4] = c[7:0]; hl = 5; exp_len = 7;
          end
          default: bad = 1;
        endcase
        if ((f == F_WR_REGS || f == F_WR_BYTES) && c == 0) begin
          push_res(K_STATUS, 8'h0, 16'h0, ST_OK);
        end else if (bad || exp_len > MaxReplyLen) begin
          push_res(K_STATUS, 8'h0, 16'h0, ST_BADARG);
        end else begin
          m_kind = f;
          m_explen = 9'(exp_len);
          m_txcrc = 16'hFFFF;
          for (int i = 0; i < hl; i++) begin
            if (i < 6) m_hdr[i] = h[i];
            push_frame(h[i]);
          end
          if (f == F_WR_REGS || f == F_WR_BYTES) begin
            m_left = c[7:0];
            m_phase = PH_SEND;
          end else begin
            push_crc();
          end
        end
      end
      OP_PAYLOAD: begin
        if (m_phase == PH_SEND) begin
          if (m_kind == F_WR_REGS) push_frame(v[15:8]);
          push_frame(v[7:0]);
          m_left = m_left - 1;
          if (m_left == 0) push_crc();
        end
      end
      OP_RXBYTE: begin
        idx = m_rxlen;
        exp_len = m_explen;
        if (m_phase == PH_RECV && exp_len >= 3 && idx < exp_len) begin
          cmp_len = (m_kind <= 1) ? 2 : ((m_kind >= 5) ? 5 : 6);
          dstart = (m_kind <= 1) ? 3 : ((m_kind == 5) ? 5 : 1023);
          m_rxlen = 9'(idx + 1);
          if (idx < exp_len - 2) begin
            m_rxcrc = crc_step(m_rxcrc, v[7:0]);
            if (idx < cmp_len && v[7:0] != m_hdr[idx]) m_mis = 1;
            if (idx >= dstart) begin
              if (m_kind == F_RD_REGS) begin
                if (((idx - dstart) & 1) == 0) m_hi = v[7:0];
                else push_res(K_DATA, 8'h0, {m_hi, v[7:0]}, ST_OK);
              end else begin
                push_res(K_DATA, 8'h0, {8'h0, v[7:0]}, ST_OK);
              end
            end
          end else if (idx == exp_len - 2) begin
            m_crclo = v[7:0];
          end else begin
            got = {v[7:0], m_crclo};
            st = (got != m_rxcrc) ? ST_CRC : (m_mis ? ST_MISMATCH : ST_OK);
            push_res(K_STATUS, 8'h0, 16'h0, st);
            m_phase = PH_IDLE;
          end
        end
      end
      default: begin
        if (m_phase == PH_RECV) begin
          m_phase = PH_IDLE;
          push_res(K_STATUS, 8'h0, 16'h0, (m_rxlen == 0) ? ST_TIMEOUT : ST_CRC);
        end
      end
    endcase
    if (expected_q.size() > n0) expected_q[$].last = 1'b1;
  endtask

  // send one item and update the prediction on acceptance; valid drops only in a gap
  task automatic send_item(logic [1:0] op, logic [7:0] s, logic [2:0] f,
                           logic [15:0] a, logic [10:0] c, logic [15:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_slave    <= s;
    in_func     <= f;
    in_mem_addr <= a;
    in_count    <= c;
    in_value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_engine(op, s, f, a, c, v);
    n_items++;
  endtask

  task automatic rand_start(logic [2:0] f, logic [10:0] c);
    send_item(OP_START, 8'($urandom), f, 16'($urandom), c, 16'($urandom));
  endtask

  task automatic send_rx(logic [7:0] b);
    send_item(OP_RXBYTE, 8'($urandom), 3'($urandom), 16'($urandom), 11'($urandom),
              {8'($urandom), b});
  endtask

  // answer the pending request: echo or header, data, CRC, with optional corruption
  task automatic send_reply(int mode);
    logic [7:0] bytes[$];
    logic [15:0] c;
    int n, dlen;
    c = 16'hFFFF;
    if (m_kind <= 1) begin
      bytes = {bytes, m_hdr[0]};
      bytes = {bytes, m_hdr[1]};
      dlen = m_explen - 5;
      bytes = {bytes, 8'(dlen)};
      for (int i = 0; i < dlen; i++) bytes = {bytes, 8'($urandom)};
    end else if (m_kind == F_RD_BYTES) begin
      for (int i = 0; i < 5; i++) bytes = {bytes, m_hdr[i]};
      for (int i = 0; i < m_explen - 7; i++) bytes = {bytes, 8'($urandom)};
    end else if (m_kind == F_WR_BYTES) begin
      for (int i = 0; i < 5; i++) bytes = {bytes, m_hdr[i]};
    end else begin
      for (int i = 0; i < 6; i++) bytes = {bytes, m_hdr[i]};
    end
    if (mode == 1) bytes[$urandom_range(0, 1)] ^= 8'h01;  // header mismatch
    foreach (bytes[i]) c = crc_step(c, bytes[i]);
    if (mode == 2) c ^= 16'h0100;                        // bad CRC
    bytes = {bytes, c[7:0]};
    bytes = {bytes, c[15:8]};
    n = bytes.size();
    if (mode == 3) n = $urandom_range(1, n - 1);         // short reply
    for (int i = 0; i < n; i++) send_rx(bytes[i]);
    if (mode >= 3) send_item(OP_RXEND, 0, 0, 0, 0, 0);
  endtask

  task automatic send_payload(int cnt);
    for (int i = 0; i < cnt; i++)
      send_item(OP_PAYLOAD, 8'($urandom), 3'($urandom), 16'($urandom), 11'($urandom),
                16'($urandom));
  endtask

  // directed extremes and special cases
  task automatic test_directed();
    send_item(OP_PAYLOAD, 8'h00, 3'd0, 16'h0, 11'd0, 16'hFFFF);  // wrong phase
    send_item(OP_RXBYTE, 8'h00, 3'd0, 16'h0, 11'd0, 16'h00FF);
    send_item(OP_RXEND, 8'h00, 3'd0, 16'h0, 11'd0, 16'h0);
    send_item(OP_START, 8'hFF, F_RD_COILS, 16'hFFFF, 11'd0, 16'h0);      // bad count
    send_item(OP_START, 8'h00, F_RD_COILS, 16'h0, 11'd2001, 16'h0);
    send_item(OP_START, 8'h00, F_RD_REGS, 16'h0, 11'd126, 16'h0);
    send_item(OP_START, 8'h00, F_WR_REGS, 16'h0, 11'd124, 16'h0);
    send_item(OP_START, 8'h00, F_RD_BYTES, 16'h0, 11'd250, 16'h0);
    send_item(OP_START, 8'h00, F_WR_BYTES, 16'h0, 11'd2047, 16'h0);
    send_item(OP_START, 8'h00, 3'd7, 16'h0, 11'd1, 16'h0);              // func seven
    send_item(OP_START, 8'h00, F_RD_COILS, 16'h0, 11'd2000, 16'h0);     // largest coil read
    send_item(OP_START, 8'h00, F_WR_REGS, 16'h0, 11'd0, 16'h0);         // empty writes
    send_item(OP_START, 8'h00, F_WR_BYTES, 16'h0, 11'd0, 16'h0);
    send_item(OP_START, 8'h11, F_WR_COIL, 16'h1234, 11'd0, 16'h0001);
    send_item(OP_RXEND, 8'h00, 3'd0, 16'h0, 11'd0, 16'h0);              // timeout
    send_item(OP_START, 8'h22, F_WR_REG, 16'hFFFF, 11'd0, 16'hFFFF);
    send_item(OP_START, 8'h01, F_RD_REGS, 16'h0, 11'd125, 16'h0);       // start while busy
    send_item(OP_START, 8'h01, F_RD_REGS, 16'h0, 11'd3, 16'h0);
    send_reply(0);
  endtask

  // random sequences over every request kind, with noise items
  task automatic test_random();
    int f, mode, c;
    while (n_items < 265) begin
      f = $urandom_range(0, 7);
      mode = $urandom_range(0, 9);
      mode = (mode < 6) ? 0 : mode - 5;
      // rare counts sit outside the limits; the others are small, so each transaction stays short
      case (f)
        0: c = ($urandom_range(0, 9) == 0) ?
               (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2001, 2047)) :
               $urandom_range(1, 24);
        1: c = ($urandom_range(0, 9) == 0) ?
               (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(126, 200)) :
               $urandom_range(1, 6);
        4: c = ($urandom_range(0, 9) == 0) ?
               (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(124, 130)) :
               $urandom_range(1, 4);
        5: c = ($urandom_range(0, 9) == 0) ?
               (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(250, 260)) :
               $urandom_range(1, 8);
        6: c = ($urandom_range(0, 9) == 0) ?
               (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(250, 260)) :
               $urandom_range(1, 8);
        default: c = $urandom_range(0, 2047);
      endcase
      if (f == 7) begin
        // noise: items in random ops
        send_item(2'($urandom), 8'($urandom), 3'($urandom), 16'($urandom),
                  11'($urandom), 16'($urandom));
      end else begin
        rand_start(3'(f), 11'(c));
        if (m_phase == PH_SEND) send_payload(m_left);
        if (m_phase == PH_RECV) begin
          if (mode == 4) send_item(OP_RXEND, 0, 0, 0, 0, 0);
          else send_reply(mode);
        end
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d act fb=%h rd=%h st=%0d last=%0b", $time,
                 out_kind, out_frame_byte, out_reply_data, out_status, out_last);
      end else begin
        e = expected_q.pop_front();
        if (e.kind !== out_kind || e.frame_byte !== out_frame_byte ||
            e.reply_data !== out_reply_data || e.status !== out_status ||
            e.last !== out_last) begin
          errors++;
          $display("%0t: mismatch exp kind=%0d fb=%h rd=%h st=%0d last=%0b", $time,
                   e.kind, e.frame_byte, e.reply_data, e.status, e.last);
          $display("%0t:          act kind=%0d fb=%h rd=%h st=%0d last=%0b", $time,
                   out_kind, out_frame_byte, out_reply_data, out_status, out_last);
        end
      end
    end
  end

  // random stall on the result side, now and then a long one
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else if (r < 60) begin
      out_stall <= 1'b0;
    end else if (r < 98) begin
      out_stall <= ($urandom_range(0, 2) == 0);
    end else begin
      out_stall <= 1'b1;
      stall_hold <= $urandom_range(5, 30);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("%0t: watchdog expired, %0d results pending", $time, expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_op = '0; in_slave = '0; in_func = '0;
    in_mem_addr = '0; in_count = '0; in_value = '0;
    m_phase = PH_IDLE; m_kind = 0; m_left = 0; m_txcrc = 16'hFFFF; m_rxcrc = 16'hFFFF;
    m_explen = 0; m_rxlen = 0; m_mis = 0; m_hi = 0; m_crclo = 0;
    foreach (m_hdr[i]) m_hdr[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d items across all request kinds, replies good and damaged;", n_items);
    $display("checked %0d results, %0d errors.", n_results, errors);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
